// ===== rtl/tlmic_pkg.sv =====
// Package for the three-level masked interrupt controller.
// Holds transaction codes, register map constants and status word codes.
// No dependencies; used by the request interface, the top level and the testbench.
package tlmic_pkg;

  // Transaction kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RAISE = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // Status word selects (register index or event type)
  localparam logic [1:0] STAT_NRM = 2'd0;
  localparam logic [1:0] STAT_EXT = 2'd1;
  localparam logic [1:0] STAT_ERR = 2'd2;

  localparam int unsigned NUM_STATUS = 3;
  localparam int unsigned NUM_LEVELS = 3;
  localparam int unsigned NUM_MASKS  = NUM_STATUS * NUM_LEVELS;

  // Register map
  localparam logic [3:0] REG_STAT_LAST = 4'd2;
  localparam logic [3:0] REG_MASK_BASE = 4'd3;
  localparam logic [3:0] REG_MASK_LAST = 4'd11;

  // Read-back composition of the normal status word
  localparam logic [31:0] NRM_LOW_BITS    = 32'h3fff_ffff;
  localparam logic [31:0] EXT_SUMMARY_BIT = 32'h4000_0000;
  localparam logic [31:0] ERR_SUMMARY_BIT = 32'h8000_0000;

endpackage

// ===== rtl/tlmic_in_if.sv =====
// Request channel of the interrupt controller: bus accesses and events.
// Depends on tlmic_pkg for the transaction kind type.
interface tlmic_in_if
  import tlmic_pkg::*;
();
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [3:0]  reg_index;
  logic [31:0] write_data;
  logic [1:0]  event_type;
  logic [31:0] event_mask;

  modport source (output valid, kind, reg_index, write_data, event_type, event_mask,
                  input ready);
  modport sink   (input valid, kind, reg_index, write_data, event_type, event_mask,
                  output ready);
endinterface

// ===== rtl/tlmic_out_if.sv =====
// Result channel of the interrupt controller: read data and level requests.
// Depends on nothing but is used alongside tlmic_pkg.
interface tlmic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level6;
  logic        irq_level4;
  logic        irq_level2;

  modport source (output valid, read_data, irq_level6, irq_level4, irq_level2,
                  input ready);
  modport sink   (input valid, read_data, irq_level6, irq_level4, irq_level2,
                  output ready);
endinterface

// ===== rtl/three_level_masked_interrupt_controller.sv =====
// Three-level masked interrupt controller with write-one-to-clear status.
// Uses tlmic_pkg, tlmic_in_if and tlmic_out_if.
//
// Usage:
//   in_i carries one transaction per handshake: a bus read or write of one of
//   twelve registers (three status words, nine level masks), or a raise or
//   clear event on one status word. out_o returns one result per transaction:
//   read data (zero unless a bus read) and the three level requests as they
//   stand after the transaction took effect.
//   A transaction is captured in an input register, then masked OR logic
//   updates the state and loads the result register. Result valid rises when
//   the transaction moves from the input register into the result register;
//   throughput is one transaction per cycle while out_o takes each result,
//   set by the single update stage on the state.
//   When out_o stalls, the result register holds and the input register
//   still takes one more transaction; after that in_i.ready drops until the
//   result is taken.
//   Reset clears all status words, all masks and both stage valid flags; the
//   block accepts a transaction as soon as reset is released.
module three_level_masked_interrupt_controller
  import tlmic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tlmic_in_if.sink    in_i,
  tlmic_out_if.source out_o
);

  // Input stage
  logic        in_valid_q;
  kind_e       kind_q;
  logic [3:0]  idx_q;
  logic [31:0] wdata_q;
  logic [1:0]  etype_q;
  logic [31:0] emask_q;

  // State
  logic [31:0] status_q [NUM_STATUS];
  logic [31:0] status_d [NUM_STATUS];
  logic [31:0] masks_q  [NUM_MASKS];
  logic [31:0] masks_d  [NUM_MASKS];

  // Result stage
  logic        out_valid_q;
  logic [31:0] rdata_q, rdata_d;
  logic [NUM_LEVELS-1:0] irq_q, irq_d;

  logic        advance;
  logic [3:0]  mask_sel;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign mask_sel   = idx_q - REG_MASK_BASE;

  // Capture the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      kind_q  <= in_i.kind;
      idx_q   <= in_i.reg_index;
      wdata_q <= in_i.write_data;
      etype_q <= in_i.event_type;
      emask_q <= in_i.event_mask;
    end
  end

  // Decode the transaction and form the next state and read data
  always_comb begin
    status_d = status_q;
    masks_d  = masks_q;
    rdata_d  = '0;
    case (kind_q)
      KIND_READ: begin
        if (idx_q == 4'(STAT_NRM)) begin
          rdata_d = status_q[STAT_NRM] & NRM_LOW_BITS;
          if (|status_q[STAT_EXT]) rdata_d = rdata_d | EXT_SUMMARY_BIT;
          if (|status_q[STAT_ERR]) rdata_d = rdata_d | ERR_SUMMARY_BIT;
        end else if (idx_q <= REG_STAT_LAST) begin
          rdata_d = status_q[idx_q[1:0]];
        end else if (idx_q <= REG_MASK_LAST) begin
          rdata_d = masks_q[mask_sel];
        end
      end
      KIND_WRITE: begin
        if (idx_q <= REG_STAT_LAST) begin
          status_d[idx_q[1:0]] = status_q[idx_q[1:0]] & ~wdata_q;
        end else if (idx_q <= REG_MASK_LAST) begin
          masks_d[mask_sel] = wdata_q;
        end
      end
      KIND_RAISE: begin
        if (etype_q <= STAT_ERR) begin
          status_d[etype_q] = status_q[etype_q] | emask_q;
        end
      end
      KIND_CLEAR: begin
        if (etype_q <= STAT_ERR) begin
          status_d[etype_q] = status_q[etype_q] & ~emask_q;
        end
      end
      default: begin
        rdata_d = '0;
      end
    endcase
  end

  // Level requests from the updated state; bit 0 is level 2, bit 2 level 6
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      irq_d[l] = |((status_d[STAT_NRM] & masks_d[NUM_STATUS*l])     |
                   (status_d[STAT_EXT] & masks_d[NUM_STATUS*l + 1]) |
                   (status_d[STAT_ERR] & masks_d[NUM_STATUS*l + 2]));
    end
  end

  // Commit the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STATUS; s++) status_q[s] <= '0;
      for (int m = 0; m < NUM_MASKS; m++)  masks_q[m]  <= '0;
    end else if (advance) begin
      status_q <= status_d;
      masks_q  <= masks_d;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = rdata_q;
  assign out_o.irq_level2 = irq_q[0];
  assign out_o.irq_level4 = irq_q[1];
  assign out_o.irq_level6 = irq_q[2];

  // Hold a pending transaction until it can advance
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input stage dropped a pending transaction");

  // Non-read transactions return zero read data
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && kind_q != KIND_READ |=> rdata_q == '0)
    else $error("non-read transaction returned nonzero read data");

  // A raise on the error status word leaves its bits set there
  a_raise_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && kind_q == KIND_RAISE && etype_q == STAT_ERR |=>
    (status_q[STAT_ERR] & $past(emask_q)) == $past(emask_q))
    else $error("raise did not set error status bits");

  // Level 2 request in the result matches the committed state
  a_level2_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> irq_q[0] == |((status_q[STAT_NRM] & masks_q[0]) |
                              (status_q[STAT_EXT] & masks_q[1]) |
                              (status_q[STAT_ERR] & masks_q[2])))
    else $error("level 2 request disagrees with state");

endmodule

// ===== tb/sv/three_level_masked_interrupt_controller_test.sv =====
// Self-checking testbench for the three-level masked interrupt controller.
// Drives directed and random transactions and checks each result against a local predictor.
// Depends on tlmic_pkg, tlmic_in_if, tlmic_out_if and the controller top level.
`timescale 1ns / 100ps

module three_level_masked_interrupt_controller_test
  import tlmic_pkg::*;
();

  // Register map and event selects as seen on the bus
  localparam logic [3:0] REG_NRM    = 4'd0;
  localparam logic [3:0] REG_EXT    = 4'd1;
  localparam logic [3:0] REG_ERR    = 4'd2;
  localparam logic [3:0] REG_L2_NRM = 4'd3;
  localparam logic [3:0] REG_L2_EXT = 4'd4;
  localparam logic [3:0] REG_L2_ERR = 4'd5;
  localparam logic [3:0] REG_L4_NRM = 4'd6;
  localparam logic [3:0] REG_L4_EXT = 4'd7;
  localparam logic [3:0] REG_L4_ERR = 4'd8;
  localparam logic [3:0] REG_L6_NRM = 4'd9;
  localparam logic [3:0] REG_L6_EXT = 4'd10;
  localparam logic [3:0] REG_L6_ERR = 4'd11;
  localparam logic [3:0] REG_HOLE_LO = 4'd12;
  localparam logic [3:0] REG_HOLE_HI = 4'd15;
  localparam logic [1:0] STAT_NONE  = 2'd3;

  localparam int unsigned RANDOM_PER_PHASE = 440;
  localparam int unsigned NUM_PHASES       = 4;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 8;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [1:0]  event_type;
    logic [31:0] event_mask;
  } irq_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level6;
    logic        irq_level4;
    logic        irq_level2;
  } irq_result_t;

  logic clk_i;
  logic rst_ni;

  tlmic_in_if  req_if ();
  tlmic_out_if rsp_if ();

  three_level_masked_interrupt_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  irq_req_t    pending_reqs[$];
  irq_result_t expected_results[$];

  // Predictor state
  logic [31:0] stat_nrm;
  logic [31:0] stat_ext;
  logic [31:0] stat_err;
  logic [31:0] level_mask[NUM_MASKS];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned total_pushed;
  int unsigned total_accepted;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        req_taken;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one transaction to the predictor state and return the result it causes
  function automatic irq_result_t predict_irq_result(irq_req_t req);
    irq_result_t res;
    logic [31:0] hit;
    int unsigned lvl;
    res = '0;
    case (req.kind)
      KIND_READ: begin
        if (req.reg_index == REG_NRM) begin
          res.read_data = stat_nrm & NRM_LOW_BITS;
          if (stat_ext != 32'd0) res.read_data |= EXT_SUMMARY_BIT;
          if (stat_err != 32'd0) res.read_data |= ERR_SUMMARY_BIT;
        end else if (req.reg_index == REG_EXT) begin
          res.read_data = stat_ext;
        end else if (req.reg_index == REG_ERR) begin
          res.read_data = stat_err;
        end else if (req.reg_index <= REG_MASK_LAST) begin
          res.read_data = level_mask[req.reg_index - REG_MASK_BASE];
        end
      end
      KIND_WRITE: begin
        if (req.reg_index == REG_NRM) stat_nrm &= ~req.write_data;
        else if (req.reg_index == REG_EXT) stat_ext &= ~req.write_data;
        else if (req.reg_index == REG_ERR) stat_err &= ~req.write_data;
        else if (req.reg_index <= REG_MASK_LAST)
          level_mask[req.reg_index - REG_MASK_BASE] = req.write_data;
      end
      default: begin
        if (req.kind == KIND_RAISE) begin
          if (req.event_type == STAT_NRM) stat_nrm |= req.event_mask;
          else if (req.event_type == STAT_EXT) stat_ext |= req.event_mask;
          else if (req.event_type == STAT_ERR) stat_err |= req.event_mask;
        end else begin
          if (req.event_type == STAT_NRM) stat_nrm &= ~req.event_mask;
          else if (req.event_type == STAT_EXT) stat_ext &= ~req.event_mask;
          else if (req.event_type == STAT_ERR) stat_err &= ~req.event_mask;
        end
      end
    endcase
    // Level outputs after the update: level 2, 4, 6 use mask groups 0, 1, 2
    for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
      hit = (stat_nrm & level_mask[lvl * 3]) | (stat_ext & level_mask[lvl * 3 + 1]) |
            (stat_err & level_mask[lvl * 3 + 2]);
      if (lvl == 0) res.irq_level2 = (hit != 32'd0);
      else if (lvl == 1) res.irq_level4 = (hit != 32'd0);
      else res.irq_level6 = (hit != 32'd0);
    end
    return res;
  endfunction

  function automatic logic roll(int unsigned pct);
    return ($urandom_range(99) < pct);
  endfunction

  // Data word biased toward sparse patterns so level outputs toggle
  function automatic logic [31:0] rand_word();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'd1 << $urandom_range(31);
      3: return $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  function automatic irq_req_t rand_req();
    irq_req_t req;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) req.kind = KIND_READ;
    else if (pick < 55) req.kind = KIND_WRITE;
    else if (pick < 85) req.kind = KIND_RAISE;
    else req.kind = KIND_CLEAR;
    req.reg_index  = roll(6) ? 4'($urandom_range(REG_HOLE_HI, REG_HOLE_LO))
                             : 4'($urandom_range(REG_MASK_LAST));
    req.event_type = roll(6) ? STAT_NONE : 2'($urandom_range(STAT_ERR));
    req.write_data = rand_word();
    req.event_mask = rand_word();
    return req;
  endfunction

  task automatic push_req(kind_e kind, logic [3:0] idx, logic [31:0] wdata,
                          logic [1:0] etype, logic [31:0] emask);
    irq_req_t req;
    req.kind       = kind;
    req.reg_index  = idx;
    req.write_data = wdata;
    req.event_type = etype;
    req.event_mask = emask;
    pending_reqs.push_back(req);
    total_pushed++;
  endtask

  // Sample both channels: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin
    irq_result_t exp_res;
    irq_result_t got_res;
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(predict_irq_result('{req_if.kind, req_if.reg_index,
          req_if.write_data, req_if.event_type, req_if.event_mask}));
        total_accepted++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_res = '{rsp_if.read_data, rsp_if.irq_level6, rsp_if.irq_level4,
                    rsp_if.irq_level2};
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected result: read_data=%h l6=%b l4=%b l2=%b", $time,
                     got_res.read_data, got_res.irq_level6, got_res.irq_level4,
                     got_res.irq_level2);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got_res !== exp_res) begin
            if (mismatch_count < 10)
              $display("[%0t] mismatch: rdata exp %h got %h, l6 %b/%b, l4 %b/%b, l2 %b/%b",
                       $time, exp_res.read_data, got_res.read_data, exp_res.irq_level6,
                       got_res.irq_level6, exp_res.irq_level4, got_res.irq_level4,
                       exp_res.irq_level2, got_res.irq_level2);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Drive inputs on the falling edge; hold a transaction until it is taken
  always @(negedge clk_i) begin
    irq_req_t req;
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (pending_reqs.size() != 0 && !roll(send_idle_pct)) begin
          req = pending_reqs.pop_front();
          req_if.kind       <= req.kind;
          req_if.reg_index  <= req.reg_index;
          req_if.write_data <= req.write_data;
          req_if.event_type <= req.event_type;
          req_if.event_mask <= req.event_mask;
          req_if.valid      <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= !roll(recv_stall_pct);
    end
  end

  // Abort on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Sequence reset, directed items and the random phases
  initial begin
    int unsigned phase;
    int unsigned n;
    stat_nrm = '0;
    stat_ext = '0;
    stat_err = '0;
    for (n = 0; n < NUM_MASKS; n++) level_mask[n] = '0;
    total_pushed   = 0;
    total_accepted = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_taken         = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_READ;
    req_if.reg_index  = '0;
    req_if.write_data = '0;
    req_if.event_type = '0;
    req_if.event_mask = '0;
    rsp_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: summary bits, hidden high normal bits, holes and ignored event type
    push_req(KIND_WRITE, REG_L2_NRM, 32'hffff_ffff, STAT_NRM, 32'd0);
    push_req(KIND_RAISE, REG_NRM, 32'd0, STAT_NRM, 32'hc000_0001);
    push_req(KIND_READ, REG_NRM, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_WRITE, REG_NRM, 32'h0000_0001, STAT_NRM, 32'd0);
    push_req(KIND_READ, REG_NRM, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_CLEAR, REG_NRM, 32'd0, STAT_NRM, 32'hffff_ffff);
    push_req(KIND_WRITE, REG_L4_EXT, 32'h8000_0000, STAT_NRM, 32'd0);
    push_req(KIND_RAISE, REG_NRM, 32'd0, STAT_EXT, 32'h8000_0000);
    push_req(KIND_RAISE, REG_NRM, 32'd0, STAT_ERR, 32'hffff_ffff);
    push_req(KIND_READ, REG_NRM, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_READ, REG_EXT, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_READ, REG_ERR, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_WRITE, REG_L6_ERR, 32'h0000_0001, STAT_NRM, 32'd0);
    push_req(KIND_READ, REG_L6_ERR, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_READ, REG_L4_EXT, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_RAISE, REG_NRM, 32'd0, STAT_NONE, 32'hffff_ffff);
    push_req(KIND_CLEAR, REG_NRM, 32'd0, STAT_NONE, 32'hffff_ffff);
    push_req(KIND_READ, REG_HOLE_LO, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_WRITE, REG_HOLE_HI, 32'hffff_ffff, STAT_NRM, 32'd0);
    push_req(KIND_READ, REG_HOLE_HI, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_WRITE, REG_ERR, 32'hffff_ffff, STAT_NRM, 32'd0);
    push_req(KIND_WRITE, REG_EXT, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_CLEAR, REG_NRM, 32'd0, STAT_EXT, 32'h8000_0000);
    push_req(KIND_READ, REG_NRM, 32'd0, STAT_NRM, 32'd0);
    push_req(KIND_WRITE, REG_L2_NRM, 32'd0, STAT_NRM, 32'd0);

    // Random phases; drain between them so the sender waits for every result
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) pending_reqs.push_back(rand_req());
      total_pushed += RANDOM_PER_PHASE;
      while (total_accepted != total_pushed || expected_results.size() != 0)
        @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
